@@ sv/hli_pkg.sv @@
package hli_pkg;

  localparam int RadiusWidth  = 32;
  localparam int IndexWidth   = 8;
  localparam int CountWidth   = 9;
  localparam int CountReset   = 2;
  localparam int ChunkWidth   = 16;
  localparam int QuotClampBit = 50;

  localparam logic CmdLoad  = 1'b0;
  localparam logic CmdQuery = 1'b1;

  typedef struct packed {
    logic load;
    logic start;
    logic hunt;
    logic prep;
    logic mul;
    logic div;
    logic fin;
  } hli_cmd_t;

  typedef struct packed {
    logic hunt_done;
    logic zero_width;
    logic mul_done;
    logic div_done;
    logic out_free;
  } hli_stat_t;

endpackage

@@ sv/hli_if.sv @@
interface hli_in_if import hli_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) ();
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic [IndexWidth-1:0]         point_index;
  logic [RadiusWidth-1:0]        radius;
  logic signed [VALUE_WIDTH-1:0] envelope_value;

  modport source (output valid, command, point_index, radius, envelope_value, input ready);
  modport sink   (input valid, command, point_index, radius, envelope_value, output ready);
endinterface

interface hli_out_if import hli_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) ();
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] envelope_out;
  logic [IndexWidth-1:0]         segment_used;
  logic                          zero_width_error;

  modport source (output valid, envelope_out, segment_used, zero_width_error, input ready);
  modport sink   (input valid, envelope_out, segment_used, zero_width_error, output ready);
endinterface

interface hli_cfg_if import hli_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CountWidth-1:0] point_count;

  modport source (output valid, point_count, input ready);
  modport sink   (input valid, point_count, output ready);
endinterface

@@ sv/hunting_linear_interpolator.sv @@
// channel  dir  beat
// in_i     in   command, point_index, radius, envelope_value
// out_o    out  envelope_out, segment_used, zero_width_error (one per query)
// cfg_i    in   point_count
//
// Load beat: written in its accept cycle; the controller stays idle and ready for the next beat.
// Query: accept, hunt over the segments, operand prep, multiply by 16-bit chunks,
// then a restoring divide by the one-bit-per-cycle divider, then the result.
// Zero-width segment: the multiply and the divide are skipped.
// Reset: hunt pointer 0, point_count 2, table contents undefined until loaded.
// A pending result in out_o does not block a new input beat; it only holds the
// next query in its final cycle.
module hunting_linear_interpolator import hli_pkg::*; #(
  parameter int MAX_POINTS  = 256,
  parameter int VALUE_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  hli_in_if.sink    in_i,
  hli_out_if.source out_o,
  hli_cfg_if.sink   cfg_i
);

  hli_cmd_t  cmd;
  hli_stat_t stat;

  assign cfg_i.ready = 1'b1;

  hli_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_command_i(in_i.command),
    .in_ready_o  (in_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  hli_datapath #(
    .MAX_POINTS (MAX_POINTS),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .cfg_we_i   (cfg_i.valid),
    .cfg_count_i(cfg_i.point_count),
    .in_index_i (in_i.point_index),
    .in_radius_i(in_i.radius),
    .in_env_i   (in_i.envelope_value),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .out_env_o  (out_o.envelope_out),
    .out_seg_o  (out_o.segment_used),
    .out_err_o  (out_o.zero_width_error)
  );

endmodule

@@ sv/hli_ctrl.sv @@
module hli_ctrl import hli_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_command_i,
  output logic      in_ready_o,
  input  hli_stat_t stat_i,
  output hli_cmd_t  cmd_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StHunt = 3'd1;
  localparam logic [2:0] StPrep = 3'd2;
  localparam logic [2:0] StMul  = 3'd3;
  localparam logic [2:0] StDiv  = 3'd4;
  localparam logic [2:0] StFin  = 3'd5;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_command_i == CmdQuery) begin
            cmd_o.start = 1'b1;
            state_d     = StHunt;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      StHunt: begin
        cmd_o.hunt = 1'b1;
        if (stat_i.hunt_done) begin
          state_d = StPrep;
        end
      end
      StPrep: begin
        cmd_o.prep = 1'b1;
        state_d    = stat_i.zero_width ? StFin : StMul;
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        if (stat_i.mul_done) begin
          state_d = StDiv;
        end
      end
      StDiv: begin
        cmd_o.div = 1'b1;
        if (stat_i.div_done) begin
          state_d = StFin;
        end
      end
      StFin: begin
        if (stat_i.out_free) begin
          cmd_o.fin = 1'b1;
          state_d   = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

@@ sv/hli_datapath.sv @@
module hli_datapath import hli_pkg::*; #(
  parameter int MAX_POINTS  = 256,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  hli_cmd_t                      cmd_i,
  output hli_stat_t                     stat_o,
  input  logic                          cfg_we_i,
  input  logic [CountWidth-1:0]         cfg_count_i,
  input  logic [IndexWidth-1:0]         in_index_i,
  input  logic [RadiusWidth-1:0]        in_radius_i,
  input  logic signed [VALUE_WIDTH-1:0] in_env_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [VALUE_WIDTH-1:0] out_env_o,
  output logic [IndexWidth-1:0]         out_seg_o,
  output logic                          out_err_o
);

  localparam int AW  = $clog2(MAX_POINTS);
  localparam int CW  = (AW + 1 > CountWidth) ? AW + 1 : CountWidth;
  localparam int PW  = RadiusWidth + VALUE_WIDTH;
  localparam int NCH = (VALUE_WIDTH + ChunkWidth - 1) / ChunkWidth;
  localparam int UW  = NCH * ChunkWidth;
  localparam int KW  = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int DCW = $clog2(PW);
  localparam int QW  = (PW > QuotClampBit + 1) ? PW : QuotClampBit + 1;
  localparam int SW  = ((VALUE_WIDTH > QuotClampBit + 1) ? VALUE_WIDTH : QuotClampBit + 1) + 2;
  localparam int RW  = RadiusWidth + 1;

  localparam logic signed [SW-1:0] SatHi =
    {{(SW - VALUE_WIDTH + 1){1'b0}}, {(VALUE_WIDTH - 1){1'b1}}};
  localparam logic signed [SW-1:0] SatLo =
    {{(SW - VALUE_WIDTH + 1){1'b1}}, {(VALUE_WIDTH - 1){1'b0}}};
  localparam logic [QW-1:0] QuotLimit = QW'(1) << QuotClampBit;

  logic [RadiusWidth-1:0]        rad_mem [MAX_POINTS];
  logic signed [VALUE_WIDTH-1:0] env_mem [MAX_POINTS];

  logic [CountWidth-1:0]         count_q;
  logic [AW-1:0]                 p_q, p_d, last;
  logic [CW-1:0]                 cnt_x;
  logic [AW-1:0]                 rd_a0, rd_a1, wr_a;
  logic                          wr_en;
  logic [RadiusWidth-1:0]        r0_q, r1_q, r_q;
  logic signed [VALUE_WIDTH-1:0] e0_q, e1_q;
  logic                          below, above;

  logic signed [RW-1:0]          d_s, a_s;
  logic signed [VALUE_WIDTH:0]   e_s;
  logic [RadiusWidth-1:0]        ud, ua;
  logic [VALUE_WIDTH-1:0]        ue;

  logic [RadiusWidth-1:0]        ua_q, ud_q, rem_q;
  logic [UW-1:0]                 ue_q;
  logic                          neg_q, err_q;
  logic [PW-1:0]                 acc_q;
  logic [KW-1:0]                 k_q;
  logic [DCW-1:0]                dcnt_q;

  logic [RadiusWidth+ChunkWidth-1:0] pp;
  logic [RW-1:0]                 rs;
  logic                          ge;

  logic [QW-1:0]                 qx;
  logic [QuotClampBit:0]         qc;
  logic signed [SW-1:0]          base, mag, sum;
  logic signed [VALUE_WIDTH-1:0] res;

  logic                          out_valid_q, out_err_q;
  logic signed [VALUE_WIDTH-1:0] out_env_q;
  logic [IndexWidth-1:0]         out_seg_q;

  // point count clamped to 2..MAX_POINTS, last segment index
  always_comb begin
    cnt_x = CW'(count_q);
    if (cnt_x < CW'(2)) begin
      last = '0;
    end else if (cnt_x > CW'(MAX_POINTS)) begin
      last = AW'(MAX_POINTS - 2);
    end else begin
      last = AW'(cnt_x - CW'(2));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CountWidth'(CountReset);
    end else if (cfg_we_i) begin
      count_q <= cfg_count_i;
    end
  end

  // hunt decision on the segment read last cycle
  assign below = r_q < r0_q;
  assign above = r_q > r1_q;

  always_comb begin
    stat_o.zero_width = (r0_q == r1_q);
    stat_o.mul_done   = (k_q == KW'(NCH - 1));
    stat_o.div_done   = (dcnt_q == DCW'(PW - 1));
    stat_o.out_free   = !out_valid_q || out_ready_i;
    stat_o.hunt_done  = !below && !above;
    if (below && p_q == '0) begin
      stat_o.hunt_done = 1'b1;
    end
    if (!below && above && p_q >= last) begin
      stat_o.hunt_done = 1'b1;
    end
  end

  always_comb begin
    p_d = p_q;
    if (cmd_i.start) begin
      p_d = (p_q > last) ? last : p_q;
    end else if (cmd_i.hunt && !stat_o.hunt_done) begin
      p_d = below ? p_q - AW'(1) : p_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q <= '0;
    end else begin
      p_q <= p_d;
    end
  end

  assign rd_a0 = p_d;
  assign rd_a1 = p_d + AW'(1);
  assign wr_en = cmd_i.load && (CW'(in_index_i) < CW'(MAX_POINTS));
  assign wr_a  = AW'(in_index_i);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      rad_mem[wr_a] <= in_radius_i;
      env_mem[wr_a] <= in_env_i;
    end
    r0_q <= rad_mem[rd_a0];
    r1_q <= rad_mem[rd_a1];
    e0_q <= env_mem[rd_a0];
    e1_q <= env_mem[rd_a1];
  end

  // operand setup
  always_comb begin
    d_s = signed'({1'b0, r1_q}) - signed'({1'b0, r0_q});
    a_s = signed'({1'b0, r_q}) - signed'({1'b0, r0_q});
    e_s = (VALUE_WIDTH + 1)'(e1_q) - (VALUE_WIDTH + 1)'(e0_q);
    ud  = d_s[RW-1] ? RadiusWidth'(-d_s) : RadiusWidth'(d_s);
    ua  = a_s[RW-1] ? RadiusWidth'(-a_s) : RadiusWidth'(a_s);
    ue  = e_s[VALUE_WIDTH] ? VALUE_WIDTH'(-e_s) : VALUE_WIDTH'(e_s);
  end

  // shift-add multiply by chunks, then restoring divide in place
  assign pp = ua_q * ue_q[k_q*ChunkWidth +: ChunkWidth];
  assign rs = {rem_q, acc_q[PW-1]};
  assign ge = rs >= {1'b0, ud_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      r_q <= in_radius_i;
    end
    if (cmd_i.prep) begin
      ua_q   <= ua;
      ud_q   <= ud;
      ue_q   <= UW'(ue);
      neg_q  <= a_s[RW-1] ^ e_s[VALUE_WIDTH] ^ d_s[RW-1];
      err_q  <= stat_o.zero_width;
      acc_q  <= '0;
      rem_q  <= '0;
      k_q    <= '0;
      dcnt_q <= '0;
    end
    if (cmd_i.mul) begin
      acc_q <= acc_q + (PW'(pp) << (k_q * ChunkWidth));
      k_q   <= k_q + KW'(1);
    end
    if (cmd_i.div) begin
      rem_q  <= ge ? RadiusWidth'(rs - {1'b0, ud_q}) : rs[RadiusWidth-1:0];
      acc_q  <= {acc_q[PW-2:0], ge};
      dcnt_q <= dcnt_q + DCW'(1);
    end
  end

  // clamp, add base, saturate
  always_comb begin
    qx   = QW'(acc_q);
    qc   = (qx > QuotLimit) ? QuotLimit[QuotClampBit:0] : qx[QuotClampBit:0];
    base = SW'(e0_q);
    mag  = signed'(SW'(qc));
    sum  = neg_q ? base - mag : base + mag;
    if (sum > SatHi) begin
      res = SatHi[VALUE_WIDTH-1:0];
    end else if (sum < SatLo) begin
      res = SatLo[VALUE_WIDTH-1:0];
    end else begin
      res = sum[VALUE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.fin) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      out_env_q <= err_q ? '0 : res;
      out_seg_q <= IndexWidth'(p_q);
      out_err_q <= err_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_env_o   = out_env_q;
  assign out_seg_o   = out_seg_q;
  assign out_err_o   = out_err_q;

endmodule
